FILE: sv/tkst_pkg.sv
// ----------------------------------------------------------------------------
// tkst_pkg: shared types and constants for the top-k score table
// Entry layout, cell control group, request codes, register map and reset
// values of the configuration registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tkst_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES_DEF = 10;
    localparam int LIST_MAX          = 10;
    localparam int RANK_W            = 4;
    localparam int SCORE_W           = 32;
    localparam int TAG_W             = 32;
    localparam int LEN_W             = 8;
    localparam int MODE_W            = 2;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 32;

    // Request codes
    localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PRELOAD = 2'd2;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_SCORE_FLOOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCORE_CEILING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NAME_LIMIT    = 2'd2;

    // Register reset values
    localparam logic [SCORE_W-1:0] SCORE_FLOOR_RST   = 32'd100;
    localparam logic [SCORE_W-1:0] SCORE_CEILING_RST = 32'd200000;
    localparam logic [LEN_W-1:0]   NAME_LIMIT_RST    = 8'd20;

    // One table entry as it travels along the chain
    typedef struct packed {
        logic               valid;
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
    } entry_t;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;   // place the offered entry in sorted order
        logic rotate;   // move every entry one cell toward the head
    } cell_op_t;

endpackage

`default_nettype wire

FILE: sv/tkst_cell.sv
// ----------------------------------------------------------------------------
// tkst_cell: one slot of the sorted chain
// Holds a single entry. On insert it keeps its entry, takes the offered one
// or takes its upper neighbor's; on rotate it takes its lower neighbor's.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tkst_cell (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire tkst_pkg::cell_op_t op,
    input  wire tkst_pkg::entry_t  new_entry,
    input  wire tkst_pkg::entry_t  prev_entry,
    input  wire tkst_pkg::entry_t  next_entry,
    input  wire                    prev_keep,
    output tkst_pkg::entry_t       entry,
    output logic                   keep
);
    import tkst_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [SCORE_W-1:0] score_reg;
    logic [SCORE_W-1:0] score_next;
    logic [TAG_W-1:0]   tag_reg;
    logic [TAG_W-1:0]   tag_next;

    // Stay in place when holding a score at least as high (ties keep order)
    assign keep = valid_reg && ($signed(score_reg) >= $signed(new_entry.score));

    assign entry.valid = valid_reg;
    assign entry.score = score_reg;
    assign entry.tag   = tag_reg;

    // Select the next content of the slot
    always_comb begin
        valid_next = valid_reg;
        score_next = score_reg;
        tag_next   = tag_reg;
        if (op.insert && !keep) begin
            if (prev_keep) begin
                valid_next = new_entry.valid;
                score_next = new_entry.score;
                tag_next   = new_entry.tag;
            end else begin
                valid_next = prev_entry.valid;
                score_next = prev_entry.score;
                tag_next   = prev_entry.tag;
            end
        end else if (op.rotate) begin
            valid_next = next_entry.valid;
            score_next = next_entry.score;
            tag_next   = next_entry.tag;
        end
    end

    // Occupancy flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        score_reg <= score_next;
        tag_reg   <= tag_next;
    end

endmodule

`default_nettype wire

FILE: sv/top_k_score_table.sv
// ----------------------------------------------------------------------------
// top_k_score_table: sorted table of the best scores with player tags
// Insert and query: the request is accepted (and the entry placed), then the
// chain rotates once per cycle (in listing only while m_ready is high) through
// a full turn; the first min(count, 10) rotations each carry a result (one for
// an empty table), first result in the cycle after acceptance. Preload and
// unused codes finish on acceptance.
// Reset (aresetn low, synchronous) empties the table and restores registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module top_k_score_table #(
    parameter int TABLE_ENTRIES = tkst_pkg::TABLE_ENTRIES_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // configuration writes
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [tkst_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [tkst_pkg::CFG_DATA_W-1:0]  cfg_data,
    // requests
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  [tkst_pkg::MODE_W-1:0]      s_mode,
    input  wire  signed [tkst_pkg::SCORE_W-1:0] s_player_score,
    input  wire  [tkst_pkg::TAG_W-1:0]       s_player_tag,
    input  wire  [tkst_pkg::LEN_W-1:0]       s_name_length,
    // listing results
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [tkst_pkg::RANK_W-1:0]      m_rank,
    output logic signed [tkst_pkg::SCORE_W-1:0] m_entry_score,
    output logic [tkst_pkg::TAG_W-1:0]       m_entry_tag,
    output logic                             m_entry_valid,
    output logic                             m_accepted,
    output logic                             m_last
);
    import tkst_pkg::*;

    localparam int CNT_W      = $clog2(TABLE_ENTRIES + 1);
    localparam int LIST_N_MAX = (TABLE_ENTRIES < LIST_MAX) ? TABLE_ENTRIES : LIST_MAX;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LIST  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [CNT_W-1:0]   step_reg;
    logic [CNT_W-1:0]   step_next;
    logic [CNT_W-1:0]   filled_reg;
    logic [CNT_W-1:0]   filled_next;
    logic               acc_reg;
    logic               acc_next;
    logic [SCORE_W-1:0] floor_reg;
    logic [SCORE_W-1:0] ceiling_reg;
    logic [LEN_W-1:0]   limit_reg;

    logic               s_fire;
    logic               m_fire;
    logic               room;
    logic               beats;
    logic               pass;
    logic [CNT_W-1:0]   list_n;
    logic               step_end;
    cell_op_t           op;
    entry_t             offer;
    entry_t             cell_entry [TABLE_ENTRIES];
    logic               cell_keep  [TABLE_ENTRIES];

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = (state_reg == ST_LIST);
    assign m_fire    = m_valid && m_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg   <= SCORE_FLOOR_RST;
            ceiling_reg <= SCORE_CEILING_RST;
            limit_reg   <= NAME_LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SCORE_FLOOR:   floor_reg   <= cfg_data;
                REG_SCORE_CEILING: ceiling_reg <= cfg_data;
                REG_NAME_LIMIT:    limit_reg   <= cfg_data[LEN_W-1:0];
                default:           ;
            endcase
        end
    end

    // Admission checks for a checked insert
    assign room  = (filled_reg < CNT_W'(TABLE_ENTRIES));
    assign beats = room ||
                   ($signed(cell_entry[TABLE_ENTRIES-1].score) <= s_player_score);
    assign pass  = beats && (s_player_score > $signed(floor_reg)) &&
                   (s_player_score < $signed(ceiling_reg)) &&
                   (s_name_length < limit_reg);

    assign offer.valid = 1'b1;
    assign offer.score = s_player_score;
    assign offer.tag   = s_player_tag;

    // Broadcast the chain command
    always_comb begin
        op.insert = s_fire && (((s_mode == MODE_INSERT) && pass) ||
                               (s_mode == MODE_PRELOAD));
        op.rotate = m_fire || (state_reg == ST_SWEEP);
    end

    // Build the chain; the tail wraps to the head for rotation
    for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
        entry_t prev_e;
        logic   prev_k;
        if (i == 0) begin : g_head
            assign prev_e = '0;
            assign prev_k = 1'b1;
        end else begin : g_body
            assign prev_e = cell_entry[i-1];
            assign prev_k = cell_keep[i-1];
        end
        tkst_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .op         (op),
            .new_entry  (offer),
            .prev_entry (prev_e),
            .next_entry (cell_entry[(i + 1) % TABLE_ENTRIES]),
            .prev_keep  (prev_k),
            .entry      (cell_entry[i]),
            .keep       (cell_keep[i])
        );
    end

    // Listing length: one result for an empty table
    always_comb begin
        if (filled_reg == '0) begin
            list_n = CNT_W'(1);
        end else if (filled_reg > CNT_W'(LIST_N_MAX)) begin
            list_n = CNT_W'(LIST_N_MAX);
        end else begin
            list_n = filled_reg;
        end
    end

    assign step_end = (step_reg == CNT_W'(TABLE_ENTRIES - 1));

    // Sequencer: accept, list from the head, finish the full rotation
    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        acc_next    = acc_reg;
        filled_next = filled_reg;
        if (op.insert && room) begin
            filled_next = filled_reg + CNT_W'(1);
        end
        case (state_reg)
            ST_IDLE: begin
                step_next = '0;
                if (s_fire && (s_mode == MODE_INSERT)) begin
                    acc_next   = pass;
                    state_next = ST_LIST;
                end else if (s_fire && (s_mode == MODE_QUERY)) begin
                    acc_next   = 1'b0;
                    state_next = ST_LIST;
                end
            end
            ST_LIST: begin
                if (m_fire) begin
                    step_next = step_reg + CNT_W'(1);
                    if (m_last) begin
                        if (step_end) begin
                            step_next  = '0;
                            state_next = ST_IDLE;
                        end else begin
                            state_next = ST_SWEEP;
                        end
                    end
                end
            end
            ST_SWEEP: begin
                step_next = step_reg + CNT_W'(1);
                if (step_end) begin
                    step_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                step_next  = '0;
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            step_reg   <= '0;
            filled_reg <= '0;
            acc_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            filled_reg <= filled_next;
            acc_reg    <= acc_next;
        end
    end

    // Result fields come straight from the head cell
    assign m_entry_valid = (filled_reg != '0);
    assign m_entry_score = m_entry_valid ? cell_entry[0].score : '0;
    assign m_entry_tag   = m_entry_valid ? cell_entry[0].tag : '0;
    assign m_rank        = RANK_W'(step_reg);
    assign m_accepted    = acc_reg;
    assign m_last        = (step_reg == list_n - CNT_W'(1));

`ifndef SYNTH
    a_ready_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("request taken while a listing is pending");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        filled_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && m_last) |=> !m_valid)
        else $error("result issued after the final result of a listing");

    a_empty_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_entry_valid) |-> (m_last && (m_rank == '0)))
        else $error("empty table listing is not a single rank zero result");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the top-k score table
// Feeds insert, query, preload and unused requests through a valid/ready
// driver, tracks the sorted table in a local scoreboard model and checks every
// listing row field by field. Bounds registers are changed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import tkst_pkg::*;

    localparam int N             = TABLE_ENTRIES_DEF;
    localparam int SETTLE_CYCLES = 2 * (N + 1);
    localparam int IDLE_LIMIT    = 2000;
    localparam int BACKLOG_AT    = 400;
    localparam int BACKLOG_HOLD  = 120;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 55;
    localparam longint SCORE_MAX = 64'sd2147483647;
    localparam longint SCORE_MIN = -64'sd2147483648;

    // Codes the package leaves unnamed
    localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
        logic [LEN_W-1:0]   len;
    } request_t;

    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
        logic               present;
        logic               accepted;
        logic               last;
    } listing_row_t;

    // Clock, reset and DUT ports
    logic                  aclk           = 1'b0;
    logic                  aresetn        = 1'b0;
    logic                  cfg_valid      = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic [MODE_W-1:0]     s_mode         = '0;
    logic [SCORE_W-1:0]    s_player_score = '0;
    logic [TAG_W-1:0]      s_player_tag   = '0;
    logic [LEN_W-1:0]      s_name_length  = '0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic [RANK_W-1:0]     m_rank;
    logic [SCORE_W-1:0]    m_entry_score;
    logic [TAG_W-1:0]      m_entry_tag;
    logic                  m_entry_valid;
    logic                  m_accepted;
    logic                  m_last;

    // Scoreboard model of the table and its registers
    logic signed [SCORE_W-1:0] slot_score [N];
    logic [TAG_W-1:0]          slot_tag   [N];
    int                        filled     = 0;
    logic signed [SCORE_W-1:0] floor_score   = SCORE_FLOOR_RST;
    logic signed [SCORE_W-1:0] ceiling_score = SCORE_CEILING_RST;
    logic [LEN_W-1:0]          name_cap      = NAME_LIMIT_RST;

    request_t     request_q [$];
    listing_row_t listing_rows [$];
    request_t     offered;
    int           requests_queued = 0;
    int           requests_sent   = 0;
    int           rows_seen       = 0;
    int           error_count     = 0;
    int           gap_left        = 0;
    int           hold_left       = 0;
    int           idle_cycles     = 0;
    bit           quiet_tail      = 1'b0;

    top_k_score_table DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_player_score (s_player_score),
        .s_player_tag   (s_player_tag),
        .s_name_length  (s_name_length),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_rank         (m_rank),
        .m_entry_score  (m_entry_score),
        .m_entry_tag    (m_entry_tag),
        .m_entry_valid  (m_entry_valid),
        .m_accepted     (m_accepted),
        .m_last         (m_last)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h",
                 $time, what, got, want);
        error_count++;
    endtask

    // List the table as the block should, highest score first
    task automatic list_table(input logic acc);
        listing_row_t row;
        if (filled == 0) begin
            row = '{rank: '0, score: '0, tag: '0, present: 1'b0,
                    accepted: acc, last: 1'b1};
            listing_rows.insert(listing_rows.size(), row);
        end
        for (int k = 0; k < filled && k < LIST_MAX; k++) begin
            row.rank     = k[RANK_W-1:0];
            row.score    = slot_score[k];
            row.tag      = slot_tag[k];
            row.present  = 1'b1;
            row.accepted = acc;
            row.last     = (k + 1 == filled || k + 1 == LIST_MAX);
            listing_rows.insert(listing_rows.size(), row);
        end
    endtask

    // Place an entry after all equal or higher scores; drop it past the end
    task automatic place_entry(input logic signed [SCORE_W-1:0] s,
                               input logic [TAG_W-1:0] tag);
        int pos;
        int i;
        pos = 0;
        while (pos < filled && slot_score[pos] >= s)
            pos++;
        if (pos < N) begin
            i = (filled < N) ? filled : N - 1;
            while (i > pos) begin
                slot_score[i] = slot_score[i-1];
                slot_tag[i]   = slot_tag[i-1];
                i--;
            end
            slot_score[pos] = s;
            slot_tag[pos]   = tag;
            if (filled < N)
                filled++;
        end
    endtask

    // Apply one accepted request to the model and queue the rows it lists
    task automatic apply_request(input request_t req);
        logic signed [SCORE_W-1:0] s;
        logic                      ok;
        s = req.score;
        case (req.mode)
            MODE_INSERT: begin
                ok = (filled < N || slot_score[filled-1] <= s) &&
                     s > floor_score && s < ceiling_score && req.len < name_cap;
                if (ok)
                    place_entry(s, req.tag);
                list_table(ok);
            end
            MODE_QUERY: begin
                list_table(1'b0);
            end
            MODE_PRELOAD: begin
                place_entry(s, req.tag);
            end
            default: ;
        endcase
    endtask

    task automatic queue_request(input logic [MODE_W-1:0] mode,
                                 input logic [SCORE_W-1:0] score,
                                 input logic [TAG_W-1:0] tag,
                                 input logic [LEN_W-1:0] len);
        request_t req;
        req = '{mode: mode, score: score, tag: tag, len: len};
        request_q.insert(request_q.size(), req);
        requests_queued++;
    endtask

    // Write one register and mirror it once the transaction completes
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SCORE_FLOOR:   floor_score   = data;
            REG_SCORE_CEILING: ceiling_score = data;
            REG_NAME_LIMIT:    name_cap      = data[LEN_W-1:0];
            default: ;
        endcase
    endtask

    // Wait for every request and row, then let the rotation settle
    task automatic wait_until_drained;
        do @(negedge aclk);
        while (requests_sent != requests_queued || listing_rows.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Scores cluster near base so ties and evictions happen often
    function automatic logic [SCORE_W-1:0] pick_score(input longint base,
                                                      input bit wide);
        longint v;
        int     r;
        r = $urandom_range(0, 19);
        if (r < 14 || (!wide && r < 18))
            v = base + longint'($urandom_range(0, 40));
        else if (r < 16)
            v = longint'(floor_score) + longint'($urandom_range(0, 2)) - 1;
        else if (r < 18)
            v = longint'(ceiling_score) + longint'($urandom_range(0, 2)) - 1;
        else if (r == 18 && wide)
            v = $signed($urandom);
        else
            v = (wide && $urandom_range(0, 1)) ? SCORE_MAX : SCORE_MIN;
        if (v > SCORE_MAX)
            v = SCORE_MAX;
        if (v < SCORE_MIN)
            v = SCORE_MIN;
        return v[SCORE_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] pick_length;
        int c;
        int r;
        c = int'(name_cap);
        r = $urandom_range(0, 9);
        if (r < 7)
            return (c == 0) ? '0 : LEN_W'($urandom_range(0, c - 1));
        else if (r == 7)
            return LEN_W'(c);
        else if (r == 8)
            return (c == 0) ? '0 : LEN_W'(c - 1);
        return LEN_W'($urandom_range(0, 255));
    endfunction

    // Drive requests; hold payload until the transaction completes
    always @(posedge aclk) begin : drive_requests
        request_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                apply_request(offered);
                requests_sent++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (request_q.size() > 0) begin
                    nxt = request_q.pop_front();
                    offered = nxt;
                    s_valid        <= 1'b1;
                    s_mode         <= nxt.mode;
                    s_player_score <= nxt.score;
                    s_player_tag   <= nxt.tag;
                    s_name_length  <= nxt.len;
                    if (!quiet_tail && $urandom_range(0, 4) == 0)
                        gap_left = $urandom_range(1, 9);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Check rows against the model and throttle m_ready
    always @(posedge aclk) begin : check_rows
        listing_row_t got;
        listing_row_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{rank: m_rank, score: m_entry_score, tag: m_entry_tag,
                        present: m_entry_valid, accepted: m_accepted, last: m_last};
                if (listing_rows.size() == 0) begin
                    report_mismatch("row with no listing pending", got.score, '0);
                end else begin
                    want = listing_rows.pop_front();
                    if (got.rank != want.rank)
                        report_mismatch("rank", 32'(got.rank), 32'(want.rank));
                    if (got.score != want.score)
                        report_mismatch("entry_score", got.score, want.score);
                    if (got.tag != want.tag)
                        report_mismatch("entry_tag", got.tag, want.tag);
                    if (got.present != want.present)
                        report_mismatch("entry_valid", 32'(got.present),
                                        32'(want.present));
                    if (got.accepted != want.accepted)
                        report_mismatch("accepted", 32'(got.accepted),
                                        32'(want.accepted));
                    if (got.last != want.last)
                        report_mismatch("last", 32'(got.last), 32'(want.last));
                end
                rows_seen++;
                // Back up the block once so it has to stall its input
                if (rows_seen == BACKLOG_AT)
                    hold_left = BACKLOG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                hold_left = $urandom_range(0, 8);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Abort when no transaction of any kind completes for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        longint               base;
        logic [SCORE_W-1:0]   fl;
        logic [SCORE_W-1:0]   ce;
        logic [LEN_W-1:0]     lim;
        logic [MODE_W-1:0]    mode;
        int                   r;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: bounds, ties, full table, drops, empty listing
        queue_request(MODE_QUERY,   32'd0,         32'h0000_0000, 8'd0);
        queue_request(MODE_INSERT,  32'd100,       32'h1111_0001, 8'd0);
        queue_request(MODE_INSERT,  32'd101,       32'h1111_0002, 8'd19);
        queue_request(MODE_INSERT,  32'd199999,    32'h1111_0003, 8'd0);
        queue_request(MODE_INSERT,  32'd200000,    32'h1111_0004, 8'd1);
        queue_request(MODE_INSERT,  32'd150,       32'h1111_0005, 8'd20);
        queue_request(MODE_INSERT,  32'd150,       32'hFFFF_FFFF, 8'd255);
        queue_request(MODE_PRELOAD, 32'h7FFF_FFFF, 32'h0000_0000, 8'd255);
        queue_request(MODE_PRELOAD, 32'd300,       32'h2222_0001, 8'd0);
        queue_request(MODE_PRELOAD, 32'd300,       32'h2222_0002, 8'd0);
        queue_request(MODE_INSERT,  32'd300,       32'h2222_0003, 8'd5);
        queue_request(MODE_UNUSED,  32'h8000_0000, 32'hDEAD_BEEF, 8'd7);
        for (int i = 0; i < 3; i++)
            queue_request(MODE_PRELOAD, 32'd250, 32'h3333_0000 + i, 8'd0);
        queue_request(MODE_INSERT,  32'd120,       32'h4444_0000, 8'd3);
        queue_request(MODE_INSERT,  32'd101,       32'h4444_0001, 8'd0);
        queue_request(MODE_INSERT,  32'd50,        32'h4444_0002, 8'd0);
        queue_request(MODE_INSERT,  32'd102,       32'h4444_0003, 8'd0);
        queue_request(MODE_PRELOAD, 32'h8000_0000, 32'h5555_0001, 8'd0);
        queue_request(MODE_PRELOAD, 32'd102,       32'h5555_0002, 8'd0);
        queue_request(MODE_INSERT,  32'h8000_0000, 32'h5555_0003, 8'd0);
        queue_request(MODE_INSERT,  32'hFFFF_FFFF, 32'h5555_0004, 8'd0);
        queue_request(MODE_QUERY,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
        wait_until_drained();

        // Random phases, each with its own bounds
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    fl = 32'h8000_0000; ce = 32'h7FFF_FFFF; lim = 8'd255;
                    base = 1000;
                end
                1: begin
                    fl = -32'sd1000; ce = 32'sd1000; lim = 8'd0;
                    base = -20;
                end
                2: begin
                    fl = 32'h7FFF_FFFF; ce = 32'h8000_0000; lim = 8'd1;
                    base = -60;
                end
                3: begin
                    fl = 2000 + $urandom_range(0, 500); ce = fl + 2;
                    lim = LEN_W'($urandom_range(1, 255));
                    base = longint'($signed(fl)) - 10;
                end
                default: begin
                    fl = 1000 * ph * ph + $urandom_range(0, 500);
                    ce = fl + $urandom_range(50, 5000);
                    lim = LEN_W'($urandom_range(1, 255));
                    base = longint'($signed(fl)) - 5;
                end
            endcase
            write_register(REG_SCORE_FLOOR, fl);
            write_register(REG_SCORE_CEILING, ce);
            write_register(REG_NAME_LIMIT, {8'($urandom_range(0, 255)), 16'h0, lim});
            if (ph == 0)
                write_register(REG_SPARE, $urandom);
            @(negedge aclk);
            if (ph == PHASES - 1)
                quiet_tail = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                r = $urandom_range(0, 19);
                if (r < 11)
                    mode = MODE_INSERT;
                else if (r < 14)
                    mode = MODE_QUERY;
                else if (r < 19)
                    mode = MODE_PRELOAD;
                else
                    mode = MODE_UNUSED;
                queue_request(mode, pick_score(base, mode != MODE_PRELOAD),
                              $urandom, pick_length());
            end
            wait_until_drained();
        end

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
